[rtl/chunked_transfer_slot_tracker_assert.svh]
// Assertion macros for the chunked transfer slot tracker checker.
// Needs clk and arst_n in the scope that expands them.
`ifndef CHUNKED_TRANSFER_SLOT_TRACKER_ASSERT_SVH
`define CHUNKED_TRANSFER_SLOT_TRACKER_ASSERT_SVH
// overlapping implication, checked while out of reset
`define CTST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctst assertion failed");
// next-cycle implication, checked while out of reset
`define CTST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctst assertion failed");
`endif

[rtl/ctst_pkg.sv]
// Shared types and constants for the chunked transfer slot tracker.
// No dependencies.
package ctst_pkg;
	localparam int CTST_SLOTS = 16;
	localparam int CTST_QUEUE_DEPTH = 2;

	// register indexes
	localparam logic [1:0] CFG_QUEUE_DEPTH = 2'd0;
	localparam logic [1:0] CFG_BATCH_LIMIT = 2'd1;
	localparam logic [1:0] CFG_CHUNK_BYTES = 2'd2;

	// operation and outcome codes
	localparam logic OP_START = 1'b0;
	localparam logic [1:0] OUTCOME_OK = 2'd0;
	localparam logic [1:0] OUTCOME_RETRY = 2'd1;

	// result status codes
	localparam logic [2:0] ST_PENDING = 3'd0;
	localparam logic [2:0] ST_DONE = 3'd1;
	localparam logic [2:0] ST_READ_EOF = 3'd2;
	localparam logic [2:0] ST_ZERO_WRITE = 3'd3;
	localparam logic [2:0] ST_OVERLONG = 3'd4;
	localparam logic [2:0] ST_FAILED = 3'd5;
	localparam logic [2:0] ST_BAD_CMD = 3'd6;

	typedef enum logic [2:0] {
		KIND_START,
		KIND_START_EMPTY,
		KIND_OK,
		KIND_OK_ZERO,
		KIND_RETRY,
		KIND_FAIL
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic is_write;
		logic [63:0] base;
		logic [31:0] len;
		logic [31:0] bytes;
	} cmd_t;

	typedef struct packed {
		logic [8:0] queue_depth;
		logic [8:0] batch_limit;
		logic [31:0] chunk_bytes;
	} cfg_t;
endpackage

[rtl/ctst_cmd_if.sv]
// Command and result channels of the chunked transfer slot tracker.
// Plain valid/ready handshake; no package needed.
interface ctst_cmd_if;
	logic valid;
	logic ready;
	logic operation;
	logic direction;
	logic [63:0] base_offset;
	logic [31:0] total_length;
	logic [1:0] outcome;
	logic [31:0] bytes_done;
	modport source (output valid, operation, direction, base_offset, total_length,
		outcome, bytes_done, input ready);
	modport sink (input valid, operation, direction, base_offset, total_length,
		outcome, bytes_done, output ready);
endinterface

interface ctst_res_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [63:0] request_offset;
	logic [31:0] request_length;
	logic [8:0] new_submissions;
	logic was_partial;
	modport source (output valid, status, request_offset, request_length,
		new_submissions, was_partial, input ready);
	modport sink (input valid, status, request_offset, request_length,
		new_submissions, was_partial, output ready);
endinterface

[rtl/ctst_front.sv]
// Front end: takes command words, classifies them and queues them.
// Uses ctst_pkg and ctst_cmd_if.
module ctst_front import ctst_pkg::*; (
	input logic clk,
	input logic arst_n,
	ctst_cmd_if.sink cmd,
	output cmd_t head,
	output logic head_valid,
	input logic pop
);
	localparam int PW = (CTST_QUEUE_DEPTH > 1) ? $clog2(CTST_QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(CTST_QUEUE_DEPTH + 1);

	cmd_t ent_q [CTST_QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;
	cmd_t cls;
	logic push;

	always_comb begin
		cls.is_write = cmd.direction;
		cls.base = cmd.base_offset;
		cls.len = cmd.total_length;
		cls.bytes = cmd.bytes_done;
		if (cmd.operation == OP_START) begin
			cls.kind = (cmd.total_length == '0) ? KIND_START_EMPTY : KIND_START;
		end else if (cmd.outcome == OUTCOME_OK) begin
			cls.kind = (cmd.bytes_done == '0) ? KIND_OK_ZERO : KIND_OK;
		end else if (cmd.outcome == OUTCOME_RETRY) begin
			cls.kind = KIND_RETRY;
		end else begin
			cls.kind = KIND_FAIL; // fatal and the unused code alike
		end
	end

	assign cmd.ready = (count_q != NW'(CTST_QUEUE_DEPTH));
	assign push = cmd.valid && cmd.ready;
	assign head_valid = (count_q != '0);
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CTST_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CTST_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + NW'(push) - NW'(pop && head_valid);
		end
	end
endmodule

[rtl/ctst_back.sv]
// Back end: slot table, refill and scan sequencer, result register.
// Uses ctst_pkg and ctst_res_if.
module ctst_back import ctst_pkg::*; #(
	parameter int SLOTS = CTST_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input cmd_t head,
	input logic head_valid,
	output logic pop,
	ctst_res_if.source res
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [8:0] SLOTS_W = 9'(SLOTS);

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_REFILL, S_SCAN, S_READ, S_EMIT} state_t;

	state_t state_q;
	logic [95:0] mem_q [SLOTS];   // {position, requested}
	logic [95:0] rd_q;
	logic [SLOTS-1:0] busy_q;
	logic active_q, is_write_q, partial_q, out_valid_q, out_partial_q;
	logic [63:0] base_q, cur_pos_q, out_off_q;
	logic [31:0] total_q, issued_q, cur_req_q, out_len_q;
	logic [8:0] busy_cnt_q, fill_q, subs_q, out_subs_q;
	logic [2:0] status_q, out_status_q;
	logic [IW-1:0] pick_q;
	logic [CW-1:0] idx_q;

	logic [8:0] depth_w, batch_w;
	logic [31:0] chunk_w, left_w, req_w, rem_w;
	logic stop_w, free_w, mem_we;
	logic [IW-1:0] mem_wa;
	logic [95:0] mem_wd;

	always_comb begin
		if (cfg.queue_depth == '0) depth_w = 9'd1;
		else if (cfg.queue_depth > SLOTS_W) depth_w = SLOTS_W;
		else depth_w = cfg.queue_depth;
		batch_w = (cfg.batch_limit == '0 || cfg.batch_limit > depth_w) ? depth_w
			: cfg.batch_limit;
		chunk_w = (cfg.chunk_bytes == '0) ? 32'd1 : cfg.chunk_bytes;
		left_w = total_q - issued_q;
		req_w = (chunk_w < left_w) ? chunk_w : left_w;
		rem_w = cur_req_q - head.bytes;
		stop_w = (9'(idx_q) >= depth_w) || (issued_q >= total_q)
			|| (busy_cnt_q >= depth_w) || (fill_q >= batch_w);
		free_w = !busy_q[idx_q[IW-1:0]];
	end

	assign pop = (state_q == S_IDLE) && head_valid;

	// one write port: refill writes a fresh chunk, a partial completion moves its slot on
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pick_q;
		mem_wd = {cur_pos_q + 64'(head.bytes), rem_w};
		if (state_q == S_REFILL) begin
			mem_we = !stop_w && free_w;
			mem_wa = idx_q[IW-1:0];
			mem_wd = {base_q + 64'(issued_q), req_w};
		end else if (pop && active_q && head.kind == KIND_OK) begin
			mem_we = (head.bytes <= cur_req_q) && (rem_w != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[idx_q[IW-1:0]];
	end

	assign res.valid = out_valid_q;
	assign res.status = out_status_q;
	assign res.request_offset = out_off_q;
	assign res.request_length = out_len_q;
	assign res.new_submissions = out_subs_q;
	assign res.was_partial = out_partial_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= '0;
			active_q <= 1'b0;
			is_write_q <= 1'b0;
			partial_q <= 1'b0;
			base_q <= '0;
			total_q <= '0;
			issued_q <= '0;
			busy_cnt_q <= '0;
			fill_q <= '0;
			subs_q <= '0;
			status_q <= ST_DONE;
			pick_q <= '0;
			idx_q <= '0;
			cur_pos_q <= '0;
			cur_req_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= ST_DONE;
			out_off_q <= '0;
			out_len_q <= '0;
			out_subs_q <= '0;
			out_partial_q <= 1'b0;
		end else begin
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						partial_q <= 1'b0;
						subs_q <= '0;
						fill_q <= '0;
						state_q <= S_EMIT;
						unique case (head.kind)
							KIND_START_EMPTY: begin
								status_q <= active_q ? ST_BAD_CMD : ST_DONE;
							end
							KIND_START: begin
								if (active_q) begin
									status_q <= ST_BAD_CMD;
								end else begin
									busy_q <= '0;
									base_q <= head.base;
									total_q <= head.len;
									is_write_q <= head.is_write;
									active_q <= 1'b1;
									issued_q <= '0;
									busy_cnt_q <= '0;
									state_q <= S_CHECK;
								end
							end
							default: begin
								if (!active_q) begin
									status_q <= ST_BAD_CMD;
								end else if (head.kind == KIND_RETRY) begin
									subs_q <= 9'd1;
									state_q <= S_CHECK;
								end else if (head.kind == KIND_OK
										&& head.bytes <= cur_req_q) begin
									partial_q <= (head.bytes < cur_req_q);
									if (rem_w != '0) begin
										subs_q <= 9'd1;
									end else begin
										busy_q[pick_q] <= 1'b0;
										busy_cnt_q <= busy_cnt_q - 9'(busy_cnt_q != '0);
									end
									state_q <= S_CHECK;
								end else begin
									// any error in a completion report ends the transfer
									busy_q <= '0;
									issued_q <= '0;
									busy_cnt_q <= '0;
									active_q <= 1'b0;
									if (head.kind == KIND_OK) status_q <= ST_OVERLONG;
									else if (head.kind == KIND_OK_ZERO)
										status_q <= is_write_q ? ST_ZERO_WRITE : ST_READ_EOF;
									else status_q <= ST_FAILED;
								end
							end
						endcase
					end
				end
				S_CHECK: begin
					if (issued_q < total_q || busy_cnt_q != '0) begin
						idx_q <= '0;
						state_q <= S_REFILL;
					end else begin
						busy_q <= '0;
						issued_q <= '0;
						active_q <= 1'b0;
						status_q <= ST_DONE;
						state_q <= S_EMIT;
					end
				end
				S_REFILL: begin
					if (stop_w) begin
						idx_q <= CW'(SLOTS - 1);
						state_q <= S_SCAN;
					end else begin
						if (free_w) begin
							busy_q[idx_q[IW-1:0]] <= 1'b1;
							issued_q <= issued_q + req_w;
							busy_cnt_q <= busy_cnt_q + 9'd1;
							fill_q <= fill_q + 9'd1;
							subs_q <= subs_q + 9'd1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (busy_q[idx_q[IW-1:0]]) begin
						pick_q <= idx_q[IW-1:0];
						state_q <= S_READ;
					end else if (idx_q == '0) begin
						busy_q <= '0;
						issued_q <= '0;
						busy_cnt_q <= '0;
						active_q <= 1'b0;
						status_q <= ST_DONE;
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_READ: begin
					cur_pos_q <= rd_q[95:32];
					cur_req_q <= rd_q[31:0];
					status_q <= ST_PENDING;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= status_q;
						out_off_q <= (status_q == ST_PENDING) ? cur_pos_q : '0;
						out_len_q <= (status_q == ST_PENDING) ? cur_req_q : '0;
						out_subs_q <= subs_q;
						out_partial_q <= partial_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/chunked_transfer_slot_tracker.sv]
// Top level of the chunked transfer slot tracker: configuration registers,
// front end and back end. Uses ctst_pkg, ctst_cmd_if, ctst_res_if.
//
// Use: cmd carries one word per start or completion report; res returns
// exactly one word per cmd word (status, presented request, submission
// count, partial flag). wr_en/wr_index/wr_data write queue_depth (0),
// batch_limit (1) and chunk_bytes (2); write only while the block is idle.
// Steps per word: decode, check for remaining work, the refill of free
// slots below the effective depth, the top-down scan from slot SLOTS-1 for
// the highest busy slot, the slot table read and the load of the result
// register; error replies go from decode straight to the result register.
// One word is in work at a time, while a two-word queue keeps accepting
// cmd words.
// Reset: registers return to depth 1, batch 1, chunk 4096; no transfer
// is active and the slot table is empty (busy flags cleared at once).
// Stall: res holds its word until taken; the back end may finish the next
// word meanwhile and waits for the result register; cmd ready drops only
// once the queue is full.
module chunked_transfer_slot_tracker import ctst_pkg::*; #(
	parameter int SLOTS = CTST_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [1:0] wr_index,
	input logic [31:0] wr_data,
	ctst_cmd_if.sink cmd,
	ctst_res_if.source res
);
	cfg_t cfg_q;
	cmd_t head;
	logic head_valid, pop;

	// register file; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.queue_depth <= 9'd1;
			cfg_q.batch_limit <= 9'd1;
			cfg_q.chunk_bytes <= 32'd4096;
		end else if (wr_en) begin
			case (wr_index)
				CFG_QUEUE_DEPTH: cfg_q.queue_depth <= wr_data[8:0];
				CFG_BATCH_LIMIT: cfg_q.batch_limit <= wr_data[8:0];
				CFG_CHUNK_BYTES: cfg_q.chunk_bytes <= wr_data;
				default: ;
			endcase
		end
	end

	// front: classify and queue
	ctst_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.head(head),
		.head_valid(head_valid),
		.pop(pop)
	);

	// back: slot table and sequencer
	ctst_back #(.SLOTS(SLOTS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.res(res)
	);
endmodule

[rtl/ctst_checker.sv]
// Port-level checks on the slot tracker's result channel, bound to the top.
// Uses ctst_pkg and chunked_transfer_slot_tracker_assert.svh.
`include "chunked_transfer_slot_tracker_assert.svh"
module ctst_port_checker import ctst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [2:0] status,
	input logic [63:0] request_offset,
	input logic [31:0] request_length,
	input logic was_partial
);
	`CTST_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status))
	`CTST_ASSERT_IMP(a_pending_len, res_valid && status == ST_PENDING, request_length != '0)
	`CTST_ASSERT_IMP(a_idle_zero, res_valid && status != ST_PENDING, request_offset == '0 && request_length == '0)
	`CTST_ASSERT_IMP(a_partial_ok, res_valid && was_partial, status == ST_PENDING || status == ST_DONE)
endmodule

bind chunked_transfer_slot_tracker ctst_port_checker u_ctst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.status(res.status),
	.request_offset(res.request_offset),
	.request_length(res.request_length),
	.was_partial(res.was_partial)
);
